// File: design/pli_pkg.sv
package pli_pkg;

   localparam int MAX_KNOTS_DEF   = 64;
   localparam int VALUE_WIDTH_DEF = 32;

   typedef enum logic [1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_APPEND = 2'd1,
      FUNC_QUERY  = 2'd2,
      FUNC_SPARE  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_NOT_INCR = 2'd2,
      STATUS_FULL     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   // control part of the search token walking the knot cells
   typedef struct packed {
      logic valid;
      logic found;
      logic has_prev;
      logic found_first;
   } tok_ctrl_type;

endpackage

// File: design/pli_if.sv
interface pli_req_if #(parameter int VALUE_WIDTH = 32);
   logic                           valid;
   logic                           ready;
   logic [1:0]                     func;
   logic signed [VALUE_WIDTH-1:0]  knot_x;
   logic signed [VALUE_WIDTH-1:0]  knot_y;
   logic signed [VALUE_WIDTH-1:0]  query_x;

   modport source (output valid, func, knot_x, knot_y, query_x, input ready);
   modport sink   (input valid, func, knot_x, knot_y, query_x, output ready);
endinterface

interface pli_rsp_if #(parameter int VALUE_WIDTH = 32);
   logic                           valid;
   logic                           ready;
   logic signed [VALUE_WIDTH-1:0]  value;
   logic [1:0]                     status;
   logic                           clamped;

   modport source (output valid, value, status, clamped, input ready);
   modport sink   (input valid, value, status, clamped, output ready);
endinterface

// File: design/pli_cell.sv
module pli_cell #(
   parameter int MAX_KNOTS   = 64,
   parameter int VALUE_WIDTH = 32,
   parameter int CELL_INDEX  = 0
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [$clog2(MAX_KNOTS+1)-1:0]       knot_count,
   input  logic                                 wr_en,
   input  logic signed [VALUE_WIDTH-1:0]        wr_x,
   input  logic signed [VALUE_WIDTH-1:0]        wr_y,
   input  pli_pkg::tok_ctrl_type                ctrl_i,
   input  logic signed [VALUE_WIDTH-1:0]        q_i,
   input  logic signed [VALUE_WIDTH-1:0]        px_i,
   input  logic signed [VALUE_WIDTH-1:0]        py_i,
   input  logic signed [VALUE_WIDTH-1:0]        hx_i,
   input  logic signed [VALUE_WIDTH-1:0]        hy_i,
   output pli_pkg::tok_ctrl_type                ctrl_o,
   output logic signed [VALUE_WIDTH-1:0]        q_o,
   output logic signed [VALUE_WIDTH-1:0]        px_o,
   output logic signed [VALUE_WIDTH-1:0]        py_o,
   output logic signed [VALUE_WIDTH-1:0]        hx_o,
   output logic signed [VALUE_WIDTH-1:0]        hy_o
);
   import pli_pkg::*;

   localparam int CW = $clog2(MAX_KNOTS+1);

   logic signed [VALUE_WIDTH-1:0] x_ff, y_ff;
   tok_ctrl_type                  ctrl_ff, ctrl_in;
   logic signed [VALUE_WIDTH-1:0] q_ff, px_ff, py_ff, hx_ff, hy_ff;
   logic signed [VALUE_WIDTH-1:0] px_in, py_in, hx_in, hy_in;
   logic                          active;

   // knot storage, written when the append lands on this slot
   always_ff @(posedge clock) begin
      if (wr_en && knot_count == CW'(CELL_INDEX)) begin
         x_ff <= wr_x;
         y_ff <= wr_y;
      end
   end

   assign active = ctrl_i.valid && !ctrl_i.found && (CW'(CELL_INDEX) < knot_count);

   always_comb begin
      ctrl_in = ctrl_i;
      px_in   = px_i;
      py_in   = py_i;
      hx_in   = hx_i;
      hy_in   = hy_i;
      if (active && x_ff >= q_i) begin
         ctrl_in.found       = 1'b1;
         ctrl_in.found_first = !ctrl_i.has_prev;
         hx_in               = x_ff;
         hy_in               = y_ff;
      end else if (active) begin
         ctrl_in.has_prev = 1'b1;
         px_in            = x_ff;
         py_in            = y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff  <= q_i;
      px_ff <= px_in;
      py_ff <= py_in;
      hx_ff <= hx_in;
      hy_ff <= hy_in;
   end

   assign ctrl_o = ctrl_ff;
   assign q_o    = q_ff;
   assign px_o   = px_ff;
   assign py_o   = py_ff;
   assign hx_o   = hx_ff;
   assign hy_o   = hy_ff;

endmodule

// File: design/pli_divider.sv
module pli_divider #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [2*VALUE_WIDTH-1:0]       dividend,
   input  logic [VALUE_WIDTH-1:0]         divisor,
   output logic                           done,
   output logic [VALUE_WIDTH-1:0]         quotient
);
   import pli_pkg::*;

   localparam int W  = VALUE_WIDTH;
   localparam int NW = $clog2(W);

   logic          busy_ff, done_ff;
   logic [NW-1:0] cnt_ff;
   logic [W:0]    rem_ff;
   logic [W-1:0]  lo_ff, div_ff;
   logic [W:0]    shifted;
   logic          fits;

   // restoring step: one quotient bit per cycle, high half already below divisor
   assign shifted = {rem_ff[W-1:0], lo_ff[W-1]};
   assign fits    = shifted >= {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == NW'(W-1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {1'b0, dividend[2*W-1:W]};
         lo_ff  <= dividend[W-1:0];
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? (shifted - {1'b0, div_ff}) : shifted;
         lo_ff  <= {lo_ff[W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = lo_ff;

endmodule

// File: design/piecewise_linear_interpolator_top.sv
// Flow: clear, append, spare and a query on an empty table go from idle straight to the
// done state; a query resolved at either end of the table first walks the token through the
// knot cells; an interpolated query walks the token, starts the divider, divides, then loads.
// Throughput: one request in flight; the next is taken in the cycle after the response loads,
// and a stalled response holds the block in the done state.
// Reset: synchronous, active high; empties the table and the pipeline, knot data is kept.
module piecewise_linear_interpolator_top #(
   parameter int MAX_KNOTS   = pli_pkg::MAX_KNOTS_DEF,
   parameter int VALUE_WIDTH = pli_pkg::VALUE_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   pli_req_if.sink   req_chan,
   pli_rsp_if.source rsp_chan
);
   import pli_pkg::*;

   localparam int W  = VALUE_WIDTH;
   localparam int CW = $clog2(MAX_KNOTS+1);

   // control
   state_type     state_ff, state_in;
   logic          req_accept;
   logic          out_free;
   logic          out_load;
   logic          div_start;
   logic          div_done;
   logic [W-1:0]  div_quot;

   // table bookkeeping
   logic [CW-1:0]        count_ff;
   logic signed [W-1:0]  last_x_ff;
   logic                 is_full, not_incr, wr_en;

   // knot cell chain, entry zero fed from the request
   tok_ctrl_type        ctrl_w [0:MAX_KNOTS];
   logic signed [W-1:0] q_w    [0:MAX_KNOTS];
   logic signed [W-1:0] px_w   [0:MAX_KNOTS];
   logic signed [W-1:0] py_w   [0:MAX_KNOTS];
   logic signed [W-1:0] hx_w   [0:MAX_KNOTS];
   logic signed [W-1:0] hy_w   [0:MAX_KNOTS];
   tok_ctrl_type        tok_end;
   logic                tok_launch;

   // interpolation operands
   logic signed [W:0]   dy;
   logic [W-1:0]        dx, dq, mag;
   logic [W-1:0]        dx_ff, dq_ff, mag_ff;
   logic signed [W-1:0] hy_ff;
   logic                neg_ff;

   // pending result and response register
   logic signed [W-1:0] res_value_ff;
   status_type          res_status_ff;
   logic                res_clamped_ff;
   logic                rsp_valid_ff;
   logic signed [W-1:0] rsp_value_ff;
   logic [1:0]          rsp_status_ff;
   logic                rsp_clamped_ff;

   assign req_accept = req_chan.valid && req_chan.ready;
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (func_type'(req_chan.func) == FUNC_QUERY && count_ff != '0) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            if (tok_end.valid) begin
               state_in = (tok_end.found && !tok_end.found_first) ? ST_MUL : ST_DONE;
            end
         end
         ST_MUL:  state_in = ST_DIV;
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_chan.ready = 1'b0;
      div_start      = 1'b0;
      out_load       = 1'b0;
      case (state_ff)
         ST_IDLE: req_chan.ready = 1'b1;
         ST_MUL:  div_start      = 1'b1;
         ST_DONE: out_load       = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // append checks: fullness first, then strictly increasing x
   assign is_full  = count_ff == CW'(MAX_KNOTS);
   assign not_incr = (count_ff != '0) && (req_chan.knot_x <= last_x_ff);
   assign wr_en    = req_accept && func_type'(req_chan.func) == FUNC_APPEND
                     && !is_full && !not_incr;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (req_accept && func_type'(req_chan.func) == FUNC_CLEAR) begin
         count_ff <= '0;
      end else if (wr_en) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         last_x_ff <= req_chan.knot_x;
      end
   end

   // launch the search token on an accepted query against a non-empty table
   assign tok_launch = req_accept && func_type'(req_chan.func) == FUNC_QUERY
                       && count_ff != '0;
   assign ctrl_w[0]  = '{valid: tok_launch, default: 1'b0};
   assign q_w[0]     = req_chan.query_x;
   assign px_w[0]    = '0;
   assign py_w[0]    = '0;
   assign hx_w[0]    = '0;
   assign hy_w[0]    = '0;

   for (genvar i = 0; i < MAX_KNOTS; i++) begin : g_cell
      pli_cell #(
         .MAX_KNOTS   (MAX_KNOTS),
         .VALUE_WIDTH (VALUE_WIDTH),
         .CELL_INDEX  (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .knot_count (count_ff),
         .wr_en      (wr_en),
         .wr_x       (req_chan.knot_x),
         .wr_y       (req_chan.knot_y),
         .ctrl_i     (ctrl_w[i]),
         .q_i        (q_w[i]),
         .px_i       (px_w[i]),
         .py_i       (py_w[i]),
         .hx_i       (hx_w[i]),
         .hy_i       (hy_w[i]),
         .ctrl_o     (ctrl_w[i+1]),
         .q_o        (q_w[i+1]),
         .px_o       (px_w[i+1]),
         .py_o       (py_w[i+1]),
         .hx_o       (hx_w[i+1]),
         .hy_o       (hy_w[i+1])
      );
   end

   assign tok_end = ctrl_w[MAX_KNOTS];

   // bracket differences; dq is never above dx so the quotient fits W bits
   assign dx  = W'(hx_w[MAX_KNOTS] - px_w[MAX_KNOTS]);
   assign dq  = W'(hx_w[MAX_KNOTS] - q_w[MAX_KNOTS]);
   assign dy  = {py_w[MAX_KNOTS][W-1], py_w[MAX_KNOTS]}
                - {hy_w[MAX_KNOTS][W-1], hy_w[MAX_KNOTS]};
   assign mag = dy[W] ? W'(-dy) : W'(dy);

   always_ff @(posedge clock) begin
      if (state_ff == ST_SCAN && tok_end.valid) begin
         dx_ff  <= dx;
         dq_ff  <= dq;
         mag_ff <= mag;
         hy_ff  <= hy_w[MAX_KNOTS];
         neg_ff <= dy[W];
      end
   end

   // multiply feeds the divider's input register directly
   pli_divider #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ((2*W)'(dq_ff) * (2*W)'(mag_ff)),
      .divisor  (dx_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // pending result: hold until the response register frees up
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               res_value_ff   <= '0;
               res_clamped_ff <= 1'b0;
               res_status_ff  <= STATUS_OK;
               case (func_type'(req_chan.func))
                  FUNC_APPEND: begin
                     if (is_full) begin
                        res_status_ff <= STATUS_FULL;
                     end else if (not_incr) begin
                        res_status_ff <= STATUS_NOT_INCR;
                     end
                  end
                  FUNC_QUERY: begin
                     if (count_ff == '0) begin
                        res_status_ff <= STATUS_EMPTY;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (tok_end.valid) begin
               if (!tok_end.found) begin
                  // beyond the last knot
                  res_value_ff   <= py_w[MAX_KNOTS];
                  res_clamped_ff <= 1'b1;
               end else if (tok_end.found_first) begin
                  // at or before the first knot
                  res_value_ff   <= hy_w[MAX_KNOTS];
                  res_clamped_ff <= q_w[MAX_KNOTS] < hx_w[MAX_KNOTS];
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               res_value_ff <= neg_ff ? (hy_ff - $signed(div_quot))
                                      : (hy_ff + $signed(div_quot));
            end
         end
         default: ;
      endcase
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_value_ff   <= res_value_ff;
         rsp_status_ff  <= res_status_ff;
         rsp_clamped_ff <= res_clamped_ff;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.value   = rsp_value_ff;
   assign rsp_chan.status  = rsp_status_ff;
   assign rsp_chan.clamped = rsp_clamped_ff;

   // the table never holds more knots than it has cells
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_KNOTS))
      else $error("knot count beyond table size");

   // a search token only leaves the chain while the query is in the scan state
   a_token_in_scan : assert property (@(posedge clock) disable iff (reset)
      tok_end.valid |-> state_ff == ST_SCAN)
      else $error("search token finished outside the scan");

   // the divider only reports back while a division is awaited
   a_div_in_div : assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide state");

   // a stalled response is never overwritten
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |-> !out_load)
      else $error("pending response overwritten");

endmodule

// File: bench/tb_piecewise_linear_interpolator_top.sv
module tb_piecewise_linear_interpolator_top;
   import pli_pkg::*;

   localparam int KNOTS  = MAX_KNOTS_DEF;
   localparam int VW     = VALUE_WIDTH_DEF;
   // cycles without any request moving before the run is declared hung
   localparam int HANG_LIMIT = 20000;

   typedef struct {
      func_type           func;
      logic signed [VW-1:0] kx;
      logic signed [VW-1:0] ky;
      logic signed [VW-1:0] qx;
   } request_type;

   typedef struct {
      logic signed [VW-1:0] value;
      status_type           status;
      logic                 clamped;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pli_req_if #(.VALUE_WIDTH(VW)) req_chan ();
   pli_rsp_if #(.VALUE_WIDTH(VW)) rsp_chan ();

   piecewise_linear_interpolator_top #(
      .MAX_KNOTS  (KNOTS),
      .VALUE_WIDTH(VW)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Requests waiting to be offered, and answers due from the block, oldest first
   request_type pending_reqs[$];
   answer_type  due_answers[$];

   int  send_idle_pct  = 0;
   int  recv_stall_pct = 0;
   bit  hold_sender    = 1'b0;
   int  fail_count     = 0;
   int  quiet_cycles   = 0;

   // Shadow of the knot table, updated as each request is accepted
   logic signed [VW-1:0] shadow_x[KNOTS];
   logic signed [VW-1:0] shadow_y[KNOTS];
   int                   shadow_count = 0;

   // Work out the answer the block owes for one accepted request
   function automatic answer_type interpolate(request_type rq);
      answer_type    ans;
      int            lo, hi, mid;
      longint        xh, xl, yh, yl, dx, dq, dy, mag, delta, q;
      logic [127:0]  prod;
      ans.value   = '0;
      ans.status  = STATUS_OK;
      ans.clamped = 1'b0;
      case (rq.func)
         FUNC_CLEAR: begin
            shadow_count = 0;
         end
         FUNC_APPEND: begin
            if (shadow_count >= KNOTS) begin
               ans.status = STATUS_FULL;
            end else if (shadow_count > 0 && rq.kx <= shadow_x[shadow_count-1]) begin
               ans.status = STATUS_NOT_INCR;
            end else begin
               shadow_x[shadow_count] = rq.kx;
               shadow_y[shadow_count] = rq.ky;
               shadow_count++;
            end
         end
         FUNC_QUERY: begin
            if (shadow_count == 0) begin
               ans.status = STATUS_EMPTY;
            end else begin
               q  = rq.qx;
               lo = 0;
               hi = shadow_count;
               while (lo < hi) begin
                  mid = lo + (hi - lo) / 2;
                  if (longint'(shadow_x[mid]) < q) lo = mid + 1;
                  else hi = mid;
               end
               if (lo >= shadow_count) begin
                  ans.value   = shadow_y[shadow_count-1];
                  ans.clamped = 1'b1;
               end else if (lo == 0) begin
                  ans.value   = shadow_y[0];
                  ans.clamped = (q < longint'(shadow_x[0]));
               end else begin
                  xh    = shadow_x[lo];
                  xl    = shadow_x[lo-1];
                  yh    = shadow_y[lo];
                  yl    = shadow_y[lo-1];
                  dx    = xh - xl;
                  dq    = xh - q;
                  dy    = yl - yh;
                  mag   = (dy < 0) ? -dy : dy;
                  prod  = 128'(dq) * 128'(mag);
                  delta = longint'(prod / 128'(dx));
                  ans.value = (dy < 0) ? VW'(yh - delta) : VW'(yh + delta);
               end
            end
         end
         default: ;
      endcase
      return ans;
   endfunction

   // Driver: offer the next request, predict on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            request_type took;
            took.func = func_type'(req_chan.func);
            took.kx   = req_chan.knot_x;
            took.ky   = req_chan.knot_y;
            took.qx   = req_chan.query_x;
            due_answers.insert(due_answers.size(), interpolate(took));
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_reqs.size() > 0 && !hold_sender &&
                $urandom_range(99) >= send_idle_pct) begin
               request_type nx;
               nx = pending_reqs.pop_front();
               req_chan.valid   <= 1'b1;
               req_chan.func    <= nx.func;
               req_chan.knot_x  <= nx.kx;
               req_chan.knot_y  <= nx.ky;
               req_chan.query_x <= nx.qx;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stall at random, compare each answer with the oldest one due
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (due_answers.size() == 0) begin
               $error("unexpected response value=%0d status=%0d", rsp_chan.value,
                      rsp_chan.status);
               fail_count++;
            end else begin
               answer_type ex;
               ex = due_answers.pop_front();
               if (rsp_chan.value !== ex.value) begin
                  $error("value: expected %0d actual %0d", ex.value, rsp_chan.value);
                  fail_count++;
               end
               if (rsp_chan.status !== ex.status) begin
                  $error("status: expected %0d actual %0d", ex.status, rsp_chan.status);
                  fail_count++;
               end
               if (rsp_chan.clamped !== ex.clamped) begin
                  $error("clamped: expected %0d actual %0d", ex.clamped,
                         rsp_chan.clamped);
                  fail_count++;
               end
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: count cycles in which neither channel completes a handshake
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic void add_req(func_type f, logic [VW-1:0] kx, logic [VW-1:0] ky,
                                   logic [VW-1:0] qx);
      request_type rq;
      rq.func = f;
      rq.kx   = kx;
      rq.ky   = ky;
      rq.qx   = qx;
      pending_reqs.insert(pending_reqs.size(), rq);
   endfunction

   // A well-formed sequence: clear, a sorted run of knots, then a spread of queries.
   // A little noise is mixed in: repeated x, stray codes, overfull tables.
   function automatic int add_sequence();
      int     n, m, i, k, added;
      int     xs[$];
      int     pick;
      logic [VW-1:0] qv;
      added = 0;
      pick  = $urandom_range(99);
      if (pick < 6) n = KNOTS + $urandom_range(2, 4);   // run past full
      else if (pick < 12) n = 1;
      else n = $urandom_range(2, 8);
      for (i = 0; i < n; i++) begin
         case ($urandom_range(3))
            0: xs.insert(xs.size(), $urandom_range(200) - 100);   // tight, small steps
            default: xs.insert(xs.size(), int'($urandom));
         endcase
      end
      if ($urandom_range(3) == 0) xs.insert(xs.size(), 32'h8000_0000);
      if ($urandom_range(3) == 0) xs.insert(xs.size(), 32'h7fff_ffff);
      xs.sort();
      add_req(FUNC_CLEAR, $urandom, $urandom, $urandom);
      added++;
      for (i = 0; i < xs.size(); i++) begin
         // skip duplicates mostly, keep some to provoke a rejection
         if (i > 0 && xs[i] == xs[i-1] && $urandom_range(3) != 0) continue;
         add_req(FUNC_APPEND, xs[i], $urandom, $urandom);
         added++;
      end
      if ($urandom_range(9) == 0) begin
         add_req(FUNC_APPEND, $urandom, $urandom, $urandom);
         added++;
      end
      m = $urandom_range(3, 10);
      for (i = 0; i < m; i++) begin
         k = $urandom_range(xs.size() - 1);
         case ($urandom_range(5))
            0: qv = xs[k];
            1: qv = xs[k] + $urandom_range(2) - 1;
            2: qv = (k > 0) ? VW'(xs[k-1] + ((longint'(xs[k]) - xs[k-1]) >>> 1)) : xs[k];
            3: qv = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: qv = $urandom;
         endcase
         add_req(FUNC_QUERY, $urandom, $urandom, qv);
         added++;
      end
      if ($urandom_range(15) == 0) begin
         add_req(FUNC_SPARE, $urandom, $urandom, $urandom);
         added++;
      end
      if ($urandom_range(11) == 0) begin
         add_req(FUNC_CLEAR, 0, 0, 0);
         add_req(FUNC_QUERY, 0, 0, $urandom);
         added += 2;
      end
      return added;
   endfunction

   // Sample away from the rising edge so the driver's updates have settled
   task automatic drain();
      @(negedge clock);
      while (pending_reqs.size() > 0 || req_chan.valid || due_answers.size() > 0)
         @(negedge clock);
   endtask

   initial begin
      int phase, count;
      int idle_tab[4];
      int stall_tab[4];
      idle_tab         = '{0, 81, 0, 27};
      stall_tab        = '{0, 0, 81, 27};
      req_chan.valid   = 1'b0;
      req_chan.func    = FUNC_CLEAR;
      req_chan.knot_x  = '0;
      req_chan.knot_y  = '0;
      req_chan.query_x = '0;
      rsp_chan.ready   = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, single knot, rejection of repeated x, exact hit,
      // extremes of x and y, spare code, then an overfull table
      add_req(FUNC_QUERY,  0, 0, 32'h8000_0000);
      add_req(FUNC_APPEND, 32'h0001_0000, 32'h7fff_ffff, 0);
      add_req(FUNC_QUERY,  0, 0, 32'h0000_0000);
      add_req(FUNC_QUERY,  0, 0, 32'h0001_0000);
      add_req(FUNC_QUERY,  0, 0, 32'h7fff_ffff);
      add_req(FUNC_APPEND, 32'h0001_0000, 32'h1234_5678, 0);
      add_req(FUNC_APPEND, 32'h0000_ffff, 0, 0);
      add_req(FUNC_APPEND, 32'h7fff_ffff, 32'h8000_0000, 0);
      add_req(FUNC_QUERY,  0, 0, 32'h4000_0000);
      add_req(FUNC_QUERY,  0, 0, 32'h7fff_fffe);
      add_req(FUNC_SPARE,  32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      add_req(FUNC_CLEAR,  0, 0, 0);
      add_req(FUNC_APPEND, 32'h8000_0000, 32'h8000_0000, 0);
      add_req(FUNC_APPEND, 32'h7fff_ffff, 32'h7fff_ffff, 0);
      add_req(FUNC_QUERY,  0, 0, 32'h0000_0000);
      add_req(FUNC_QUERY,  0, 0, 32'h8000_0001);
      add_req(FUNC_QUERY,  0, 0, 32'h8000_0000);
      add_req(FUNC_CLEAR,  0, 0, 0);
      for (int i = 0; i < KNOTS; i++)
         add_req(FUNC_APPEND, i * 32'h0100_0000 - 32'h4000_0000, $urandom, 0);
      add_req(FUNC_APPEND, 32'h7fff_ffff, 0, 0);
      add_req(FUNC_APPEND, 32'h8000_0000, 0, 0);
      add_req(FUNC_QUERY,  0, 0, 32'h3e80_0000);
      add_req(FUNC_QUERY,  0, 0, 32'h0080_0000);

      // Wait until every answer so far has come home, then hold the sender back for a random pause
      drain();
      hold_sender = 1'b1;
      repeat ($urandom_range(5, 40)) @(posedge clock);
      hold_sender = 1'b0;

      for (phase = 0; phase < 4; phase++) begin
         send_idle_pct  = idle_tab[phase];
         recv_stall_pct = stall_tab[phase];
         count = 0;
         while (count < 250) count += add_sequence();
         drain();
      end

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      drain();
      repeat (KNOTS + VW + 40) @(posedge clock);
      if (due_answers.size() > 0) begin
         $error("%0d responses never arrived", due_answers.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: piecewise_linear_interpolator_top.f
design/pli_pkg.sv
design/pli_if.sv
design/pli_cell.sv
design/pli_divider.sv
design/piecewise_linear_interpolator_top.sv
bench/tb_piecewise_linear_interpolator_top.sv
